// File: design/suffix_max_monotonic_stack_unit_macros.svh
// ----------------------------------------------------------------------------
// suffix_max_monotonic_stack_unit_macros
// assertion macros used by suffix_max_monotonic_stack_unit
// ----------------------------------------------------------------------------
`ifndef SUFFIX_MAX_MONOTONIC_STACK_UNIT_MACROS_SVH
`define SUFFIX_MAX_MONOTONIC_STACK_UNIT_MACROS_SVH

// same-cycle implication
`define SMMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/smms_pkg.sv
// ----------------------------------------------------------------------------
// smms_pkg
// shared types and constants of the suffix maximum monotonic stack
// ----------------------------------------------------------------------------
package smms_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int VAL_W       = 31;
    localparam int SEQ_W       = 32;
    localparam int GRP         = 32;
    localparam int NGRP        = (STACK_DEPTH + GRP - 1) / GRP;

    // one stored stack entry
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [SEQ_W-1:0] seq;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic             append;
        logic             shift;
        logic [VAL_W-1:0] value;
        logic [SEQ_W-1:0] seq;
        logic [VAL_W-1:0] len;
        logic [SEQ_W-1:0] seq_cnt;
    } t_cell_ctl;

endpackage

// File: design/smms_divider.sv
// ----------------------------------------------------------------------------
// smms_divider
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smms_divider
    import smms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W:0]   i_dividend,
    input  logic [VAL_W-1:0] i_divisor,
    output logic             o_done,
    output logic [VAL_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(VAL_W + 2);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_rem, n_rem;
    logic [VAL_W:0]   r_num, n_num;
    logic [VAL_W:0]   w_trial;

    assign w_trial = {r_rem, r_num[VAL_W]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        if (i_start) begin
            if (i_divisor == '0) begin
                n_rem  = i_dividend[VAL_W-1:0];
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_rem  = '0;
                n_num  = i_dividend;
                n_cnt  = CNT_W'(VAL_W + 1);
            end
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = VAL_W'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = w_trial[VAL_W-1:0];
            end
            n_num = {r_num[VAL_W-1:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: design/smms_cell.sv
// ----------------------------------------------------------------------------
// smms_cell
// one stack slot: pop test, push, shift and window test
// ----------------------------------------------------------------------------
module smms_cell
    import smms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_kept_prev,
    input  logic      i_pass_prev,
    input  t_entry    i_up,
    output logic      o_kept,
    output logic      o_pass,
    output logic      o_sel,
    output t_entry    o_entry
);

    logic             r_valid;
    logic [VAL_W-1:0] r_value;
    logic [SEQ_W-1:0] r_seq;
    logic [SEQ_W-1:0] w_age;

    assign o_kept  = r_valid && (r_value > i_ctl.value);
    assign w_age   = i_ctl.seq_cnt - r_seq;
    assign o_pass  = r_valid && (w_age < {1'b0, i_ctl.len});
    assign o_sel   = o_pass && !i_pass_prev;
    assign o_entry = '{valid: r_valid, value: r_value, seq: r_seq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_up.valid;
        end else if (i_ctl.append && !o_kept) begin
            r_valid <= i_kept_prev;
        end
        if (i_ctl.shift) begin
            r_value <= i_up.value;
            r_seq   <= i_up.seq;
        end else if (i_ctl.append && !o_kept && i_kept_prev) begin
            r_value <= i_ctl.value;
            r_seq   <= i_ctl.seq;
        end
    end

endmodule

// File: design/suffix_max_monotonic_stack_unit.sv
// append: accept, remainder from the divider, then push
// query: accept, window test into group registers, then to output
// one item in flight at a time; the remainder unit sets the append rate
// a query result waits in the output register while the next item is taken
// reset (synchronous, active low) empties the stack, clears sequence, answer
// and overflow flag, and sets modulus to its largest value
// ----------------------------------------------------------------------------
// suffix_max_monotonic_stack_unit
// sliding window maximum kept as a monotonic stack in a row of cells
// ----------------------------------------------------------------------------
`include "suffix_max_monotonic_stack_unit_macros.svh"

module suffix_max_monotonic_stack_unit
    import smms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [VAL_W-1:0] i_operand,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAL_W-1:0] o_max_value,
    output logic             o_found,
    output logic             o_overflowed
);

    // controller states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_QRY  = 3'd3;
    localparam logic [2:0] ST_RED  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [VAL_W-1:0] r_modulus;
    logic [SEQ_W-1:0] r_seq_cnt;
    logic [VAL_W-1:0] r_last;
    logic             r_ovf;
    logic [VAL_W-1:0] r_opnd;
    logic [VAL_W-1:0] r_newval;
    logic             r_ovld;
    logic [VAL_W-1:0] r_omax;
    logic             r_ofound;
    logic             r_oovf;

    logic             w_take;
    logic             w_div_start;
    logic             w_div_done;
    logic [VAL_W-1:0] w_rem;
    logic             w_out_free;
    logic             w_full;
    t_cell_ctl        w_ctl;

    // per-cell neighbor signals, fixed wiring along the row
    logic             w_kept [STACK_DEPTH];
    logic             w_pass [STACK_DEPTH];
    logic             w_sel  [STACK_DEPTH];
    t_entry           w_ent  [STACK_DEPTH];
    t_entry           w_up   [STACK_DEPTH];
    logic [VAL_W-1:0] r_grp  [NGRP];
    logic [VAL_W-1:0] w_grp  [NGRP];
    logic [VAL_W-1:0] w_best;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_take     = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_ovld || !i_out_stall;
    assign w_div_start = w_take && !i_mode;

    // sum at full width, then reduce by the modulus
    smms_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({1'b0, r_last} + {1'b0, i_operand}),
        .i_divisor  (r_modulus),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // every cell kept means the row is full: shift out the oldest entry
    assign w_full = w_kept[STACK_DEPTH-1];

    always_comb begin
        w_ctl.append  = (r_state == ST_PUSH);
        w_ctl.shift   = (r_state == ST_PUSH) && w_full;
        w_ctl.value   = r_newval;
        w_ctl.seq     = r_seq_cnt + 1'b1;
        w_ctl.len     = (r_opnd == '0) ? VAL_W'(1) : r_opnd;
        w_ctl.seq_cnt = r_seq_cnt;
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            if (gi == STACK_DEPTH - 1) begin : g_top
                assign w_up[gi] = '{valid: 1'b1, value: r_newval, seq: w_ctl.seq};
            end else begin : g_mid
                assign w_up[gi] = w_ent[gi+1];
            end
            smms_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_kept_prev ((gi == 0) ? 1'b1 : w_kept[(gi == 0) ? 0 : gi-1]),
                .i_pass_prev ((gi == 0) ? 1'b0 : w_pass[(gi == 0) ? 0 : gi-1]),
                .i_up        (w_up[gi]),
                .o_kept      (w_kept[gi]),
                .o_pass      (w_pass[gi]),
                .o_sel       (w_sel[gi]),
                .o_entry     (w_ent[gi])
            );
        end

        // first level of the answer tree: one-hot select inside each group
        for (gi = 0; gi < NGRP; gi++) begin : g_grp
            always_comb begin
                w_grp[gi] = '0;
                for (int k = 0; k < GRP; k++) begin
                    if (gi * GRP + k < STACK_DEPTH) begin
                        if (w_sel[gi * GRP + k]) begin
                            w_grp[gi] = w_grp[gi] | w_ent[gi * GRP + k].value;
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (r_state == ST_QRY) begin
                    r_grp[gi] <= w_grp[gi];
                end
            end
        end
    endgenerate

    // second level: combine the registered group results
    always_comb begin
        w_best = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_best = w_best | r_grp[g];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = i_mode ? ST_QRY : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: n_state = ST_IDLE;
            ST_QRY:  n_state = ST_RED;
            ST_RED: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= {VAL_W{1'b1}};
            r_seq_cnt <= '0;
            r_last    <= '0;
            r_ovf     <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_data;
            end
            if (r_state == ST_PUSH) begin
                r_seq_cnt <= r_seq_cnt + 1'b1;
                if (w_full) begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == ST_RED && w_out_free) begin
                r_ovld <= 1'b1;
                if (w_ent[0].valid) begin
                    r_last <= w_best;
                end
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
        if (w_take) begin
            r_opnd <= i_operand;
        end
        if (w_div_done) begin
            r_newval <= w_rem;
        end
        if (r_state == ST_RED && w_out_free) begin
            r_omax   <= w_ent[0].valid ? w_best : '0;
            r_ofound <= w_ent[0].valid;
            r_oovf   <= r_ovf;
        end
    end

    assign o_out_valid  = r_ovld;
    assign o_max_value  = r_omax;
    assign o_found      = r_ofound;
    assign o_overflowed = r_oovf;

    `SMMS_ASSERT_NEXT(a_push_one_cycle, r_state == ST_PUSH, r_state == ST_IDLE, "push overran")
    `SMMS_ASSERT_NEXT(a_ovf_sticky, r_ovf, r_ovf, "overflow flag cleared")
    `SMMS_ASSERT_NOW(a_empty_zero, o_out_valid && !o_found, o_max_value == '0, "empty not zero")
    `SMMS_ASSERT_NOW(a_div_in_div, w_div_done, r_state == ST_DIV, "stray remainder")

endmodule
